// ----- rtl/qte_pkg.sv -----
// Shared types, widths and constants of the quaternion to Euler angle converter.
// Used by every module in rtl/; depends on nothing else.
`default_nettype none

package qte_pkg;

  localparam int IN_W      = 16;  // quaternion component width
  localparam int OUT_W     = 16;  // angle field width
  localparam int PROD_W    = 32;  // product of two components
  localparam int NORM_W    = 33;  // squared norm, at most 2^32
  localparam int OP_W      = 35;  // atan2 operands, magnitude at most 2^32
  localparam int QUO_W     = 31;  // yaw ratio in Q1.30, at most 2^30
  localparam int REM_W     = 34;  // divider partial remainder, below twice the norm
  localparam int RAD_W     = 62;  // square root radicand, padded to an even width
  localparam int SQR_W     = 34;  // square root partial remainder
  localparam int CRD_W     = 46;  // CORDIC x and y after normalization and growth
  localparam int MAG_W     = 42;  // OR of operand magnitudes during normalization
  localparam int LIMIT_BIT = 40;  // operands are doubled until one reaches 2^40
  localparam int ANG_W     = 28;  // angle accumulator, degrees with 16 fraction bits
  localparam int ACC_FRAC  = 16;
  localparam int TABLE_LEN = 24;

  // Register stages of the atan2 unit ahead of its CORDIC iterations.
  localparam int ATAN_PRE_STAGES = 5;

  localparam logic signed [ANG_W-1:0] DEG90  = ANG_W'(90 * (2 ** ACC_FRAC));
  localparam logic signed [ANG_W-1:0] DEG180 = ANG_W'(180 * (2 ** ACC_FRAC));
  localparam logic [RAD_W-1:0]        RAD_ONE = RAD_W'(1) << 60;

  typedef struct packed {
    logic signed [IN_W-1:0] quat_x;
    logic signed [IN_W-1:0] quat_y;
    logic signed [IN_W-1:0] quat_z;
    logic signed [IN_W-1:0] quat_w;
  } quat_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] pitch_deg;
    logic [OUT_W-1:0] yaw_deg;
    logic [OUT_W-1:0] roll_deg;
    logic             degenerate;
  } euler_out_t;

  // Data that rides along the yaw ratio path.
  typedef struct packed {
    logic                   degenerate;
    logic                   s_neg;
    logic signed [OP_W-1:0] pitch_y;
    logic signed [OP_W-1:0] pitch_x;
    logic signed [OP_W-1:0] roll_y;
    logic signed [OP_W-1:0] roll_x;
  } side_t;

  // Flags that ride alongside the three atan2 units.
  typedef struct packed {
    logic degenerate;
    logic s_neg;
    logic sat;
  } flag_t;

  // atan(2^-i) in degrees with 16 fraction bits, rounded.
  function automatic logic signed [ANG_W-1:0] atan_tab(input int idx);
    logic signed [ANG_W-1:0] val;
    unique case (idx)
      0:  val = ANG_W'(2949120);
      1:  val = ANG_W'(1740967);
      2:  val = ANG_W'(919879);
      3:  val = ANG_W'(466945);
      4:  val = ANG_W'(234379);
      5:  val = ANG_W'(117304);
      6:  val = ANG_W'(58666);
      7:  val = ANG_W'(29335);
      8:  val = ANG_W'(14668);
      9:  val = ANG_W'(7334);
      10: val = ANG_W'(3667);
      11: val = ANG_W'(1833);
      12: val = ANG_W'(917);
      13: val = ANG_W'(458);
      14: val = ANG_W'(229);
      15: val = ANG_W'(115);
      16: val = ANG_W'(57);
      17: val = ANG_W'(29);
      18: val = ANG_W'(14);
      19: val = ANG_W'(7);
      20: val = ANG_W'(4);
      21: val = ANG_W'(2);
      22: val = ANG_W'(1);
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/qte_yaw_ratio.sv -----
// Pipelined yaw ratio path: restoring divider |s| * 2^30 / n, one bit a stage,
// then sqrt(2^60 - t^2), one digit a stage. Depends on qte_pkg.
`default_nettype none

module qte_yaw_ratio (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       en,
  input  logic                       in_valid,
  input  logic [qte_pkg::NORM_W-1:0] in_mag,
  input  logic [qte_pkg::NORM_W-1:0] in_norm,
  input  qte_pkg::side_t             in_side,
  output logic                       out_valid,
  output logic [qte_pkg::QUO_W-1:0]  out_ratio,
  output logic [qte_pkg::QUO_W-1:0]  out_root,
  output qte_pkg::side_t             out_side
);
  import qte_pkg::*;

  localparam int SQ_STAGES = RAD_W / 2;

  // Divider stages; index 0 holds the captured operands.
  logic              dv_r    [0:QUO_W];
  logic [REM_W-1:0]  drem_r  [0:QUO_W];
  logic [NORM_W-1:0] dden_r  [0:QUO_W];
  logic [QUO_W-1:0]  dquo_r  [0:QUO_W];
  side_t             dside_r [0:QUO_W];
  logic [REM_W-1:0]  drem_nxt [0:QUO_W-1];
  logic [QUO_W-1:0]  dquo_nxt [0:QUO_W-1];

  // Squaring stage.
  logic              sqv_r;
  logic [RAD_W-1:0]  sq_r;
  logic [QUO_W-1:0]  sqtm_r;
  side_t             sqside_r;
  logic [RAD_W-1:0]  sq_nxt;

  // Square root stages; index 0 holds the radicand.
  logic              sv_r    [0:SQ_STAGES];
  logic [RAD_W-1:0]  srad_r  [0:SQ_STAGES];
  logic [SQR_W-1:0]  srem_r  [0:SQ_STAGES];
  logic [QUO_W-1:0]  sroot_r [0:SQ_STAGES];
  logic [QUO_W-1:0]  stm_r   [0:SQ_STAGES];
  side_t             sside_r [0:SQ_STAGES];
  logic [RAD_W-1:0]  srad_nxt  [0:SQ_STAGES-1];
  logic [SQR_W-1:0]  srem_nxt  [0:SQ_STAGES-1];
  logic [QUO_W-1:0]  sroot_nxt [0:SQ_STAGES-1];

  always_comb begin
    logic             ge;
    logic [REM_W-1:0] diff;
    for (int k = 0; k < QUO_W; k++) begin
      ge          = drem_r[k] >= REM_W'(dden_r[k]);
      diff        = ge ? drem_r[k] - REM_W'(dden_r[k]) : drem_r[k];
      drem_nxt[k] = diff << 1;
      dquo_nxt[k] = {dquo_r[k][QUO_W-2:0], ge};
    end
  end

  assign sq_nxt = RAD_W'(dquo_r[QUO_W]) * RAD_W'(dquo_r[QUO_W]);

  always_comb begin
    logic             ge;
    logic [SQR_W+1:0] r2;
    logic [SQR_W+1:0] trial;
    for (int k = 0; k < SQ_STAGES; k++) begin
      r2           = {srem_r[k], srad_r[k][RAD_W-1 -: 2]};
      trial        = (SQR_W+2)'({sroot_r[k], 2'b01});
      ge           = r2 >= trial;
      srem_nxt[k]  = ge ? SQR_W'(r2 - trial) : SQR_W'(r2);
      sroot_nxt[k] = {sroot_r[k][QUO_W-2:0], ge};
      srad_nxt[k]  = srad_r[k] << 2;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k <= QUO_W; k++) dv_r[k] <= 1'b0;
      sqv_r <= 1'b0;
      for (int k = 0; k <= SQ_STAGES; k++) sv_r[k] <= 1'b0;
    end else if (en) begin
      dv_r[0] <= in_valid;
      for (int k = 0; k < QUO_W; k++) dv_r[k+1] <= dv_r[k];
      sqv_r <= dv_r[QUO_W];
      sv_r[0] <= sqv_r;
      for (int k = 0; k < SQ_STAGES; k++) sv_r[k+1] <= sv_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      drem_r[0]  <= REM_W'(in_mag);
      dden_r[0]  <= in_norm;
      dquo_r[0]  <= '0;
      dside_r[0] <= in_side;
      for (int k = 0; k < QUO_W; k++) begin
        drem_r[k+1]  <= drem_nxt[k];
        dden_r[k+1]  <= dden_r[k];
        dquo_r[k+1]  <= dquo_nxt[k];
        dside_r[k+1] <= dside_r[k];
      end
      sq_r     <= sq_nxt;
      sqtm_r   <= dquo_r[QUO_W];
      sqside_r <= dside_r[QUO_W];
      srad_r[0]  <= RAD_ONE - sq_r;
      srem_r[0]  <= '0;
      sroot_r[0] <= '0;
      stm_r[0]   <= sqtm_r;
      sside_r[0] <= sqside_r;
      for (int k = 0; k < SQ_STAGES; k++) begin
        srad_r[k+1]  <= srad_nxt[k];
        srem_r[k+1]  <= srem_nxt[k];
        sroot_r[k+1] <= sroot_nxt[k];
        stm_r[k+1]   <= stm_r[k];
        sside_r[k+1] <= sside_r[k];
      end
    end
  end

  assign out_valid = sv_r[SQ_STAGES];
  assign out_ratio = stm_r[SQ_STAGES];
  assign out_root  = sroot_r[SQ_STAGES];
  assign out_side  = sside_r[SQ_STAGES];

endmodule

`default_nettype wire

// ----- rtl/qte_atan2.sv -----
// Pipelined atan2 in degrees: operand normalization, half-plane fold and a
// vectoring CORDIC with one iteration per stage. Depends on qte_pkg.
`default_nettype none

module qte_atan2 #(
  parameter int CORDIC_STEPS = 16
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             en,
  input  logic                             in_valid,
  input  logic signed [qte_pkg::OP_W-1:0]  in_y,
  input  logic signed [qte_pkg::OP_W-1:0]  in_x,
  output logic                             out_valid,
  output logic signed [qte_pkg::ANG_W-1:0] out_angle
);
  import qte_pkg::*;

  localparam int N = CORDIC_STEPS;

  logic signed [OP_W-1:0]  ax, ay;

  logic                    n0_v_r, n1_v_r, n2_v_r, n3_v_r;
  logic                    n0_zero_r, n1_zero_r, n2_zero_r, n3_zero_r;
  logic signed [CRD_W-1:0] n0_x_r, n1_x_r, n2_x_r, n3_x_r;
  logic signed [CRD_W-1:0] n0_y_r, n1_y_r, n2_y_r, n3_y_r;
  logic [MAG_W-1:0]        n0_m_r, n1_m_r, n2_m_r;
  logic signed [CRD_W-1:0] n1_x_nxt, n2_x_nxt, n3_x_nxt;
  logic signed [CRD_W-1:0] n1_y_nxt, n2_y_nxt, n3_y_nxt;
  logic [MAG_W-1:0]        n1_m_nxt, n2_m_nxt, n3_m_nxt;

  logic                    cv_r    [0:N];
  logic                    czero_r [0:N];
  logic signed [CRD_W-1:0] cx_r    [0:N];
  logic signed [CRD_W-1:0] cy_r    [0:N];
  logic signed [ANG_W-1:0] cz_r    [0:N];
  logic signed [CRD_W-1:0] cx_nxt  [0:N-1];
  logic signed [CRD_W-1:0] cy_nxt  [0:N-1];
  logic signed [ANG_W-1:0] cz_nxt  [0:N-1];

  assign ax = in_x[OP_W-1] ? -in_x : in_x;
  assign ay = in_y[OP_W-1] ? -in_y : in_y;

  // Doubling until one magnitude reaches 2^40, done as a binary search on
  // the shift count: each step shifts only while the result stays below it.
  always_comb begin
    n1_x_nxt = n0_x_r;
    n1_y_nxt = n0_y_r;
    n1_m_nxt = n0_m_r;
    if ((n1_m_nxt >> (LIMIT_BIT - 32)) == '0) begin
      n1_x_nxt = n1_x_nxt <<< 32;
      n1_y_nxt = n1_y_nxt <<< 32;
      n1_m_nxt = n1_m_nxt << 32;
    end
    if ((n1_m_nxt >> (LIMIT_BIT - 16)) == '0) begin
      n1_x_nxt = n1_x_nxt <<< 16;
      n1_y_nxt = n1_y_nxt <<< 16;
      n1_m_nxt = n1_m_nxt << 16;
    end
  end

  always_comb begin
    n2_x_nxt = n1_x_r;
    n2_y_nxt = n1_y_r;
    n2_m_nxt = n1_m_r;
    if ((n2_m_nxt >> (LIMIT_BIT - 8)) == '0) begin
      n2_x_nxt = n2_x_nxt <<< 8;
      n2_y_nxt = n2_y_nxt <<< 8;
      n2_m_nxt = n2_m_nxt << 8;
    end
    if ((n2_m_nxt >> (LIMIT_BIT - 4)) == '0) begin
      n2_x_nxt = n2_x_nxt <<< 4;
      n2_y_nxt = n2_y_nxt <<< 4;
      n2_m_nxt = n2_m_nxt << 4;
    end
  end

  // The final single doubling carries the larger magnitude across 2^40.
  always_comb begin
    n3_x_nxt = n2_x_r;
    n3_y_nxt = n2_y_r;
    n3_m_nxt = n2_m_r;
    if ((n3_m_nxt >> (LIMIT_BIT - 2)) == '0) begin
      n3_x_nxt = n3_x_nxt <<< 2;
      n3_y_nxt = n3_y_nxt <<< 2;
      n3_m_nxt = n3_m_nxt << 2;
    end
    if ((n3_m_nxt >> (LIMIT_BIT - 1)) == '0) begin
      n3_x_nxt = n3_x_nxt <<< 1;
      n3_y_nxt = n3_y_nxt <<< 1;
      n3_m_nxt = n3_m_nxt << 1;
    end
    if ((n3_m_nxt >> LIMIT_BIT) == '0) begin
      n3_x_nxt = n3_x_nxt <<< 1;
      n3_y_nxt = n3_y_nxt <<< 1;
    end
  end

  always_comb begin
    logic signed [CRD_W-1:0] xs;
    logic signed [CRD_W-1:0] ys;
    for (int i = 0; i < N; i++) begin
      xs = cx_r[i] >>> i;
      ys = cy_r[i] >>> i;
      if (cy_r[i] > 0) begin
        cx_nxt[i] = cx_r[i] + ys;
        cy_nxt[i] = cy_r[i] - xs;
        cz_nxt[i] = cz_r[i] + atan_tab(i);
      end else begin
        cx_nxt[i] = cx_r[i] - ys;
        cy_nxt[i] = cy_r[i] + xs;
        cz_nxt[i] = cz_r[i] - atan_tab(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      n0_v_r <= 1'b0;
      n1_v_r <= 1'b0;
      n2_v_r <= 1'b0;
      n3_v_r <= 1'b0;
      for (int i = 0; i <= N; i++) cv_r[i] <= 1'b0;
    end else if (en) begin
      n0_v_r <= in_valid;
      n1_v_r <= n0_v_r;
      n2_v_r <= n1_v_r;
      n3_v_r <= n2_v_r;
      cv_r[0] <= n3_v_r;
      for (int i = 0; i < N; i++) cv_r[i+1] <= cv_r[i];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      n0_x_r    <= CRD_W'(in_x);
      n0_y_r    <= CRD_W'(in_y);
      n0_m_r    <= MAG_W'(ax) | MAG_W'(ay);
      n0_zero_r <= (in_x == '0) && (in_y == '0);
      n1_x_r    <= n1_x_nxt;
      n1_y_r    <= n1_y_nxt;
      n1_m_r    <= n1_m_nxt;
      n1_zero_r <= n0_zero_r;
      n2_x_r    <= n2_x_nxt;
      n2_y_r    <= n2_y_nxt;
      n2_m_r    <= n2_m_nxt;
      n2_zero_r <= n1_zero_r;
      n3_x_r    <= n3_x_nxt;
      n3_y_r    <= n3_y_nxt;
      n3_zero_r <= n2_zero_r;
      // A negative x folds into the right half plane with 180 degrees added.
      cx_r[0]    <= n3_x_r[CRD_W-1] ? -n3_x_r : n3_x_r;
      cy_r[0]    <= n3_x_r[CRD_W-1] ? -n3_y_r : n3_y_r;
      cz_r[0]    <= n3_x_r[CRD_W-1] ? DEG180 : '0;
      czero_r[0] <= n3_zero_r;
      for (int i = 0; i < N; i++) begin
        cx_r[i+1]    <= cx_nxt[i];
        cy_r[i+1]    <= cy_nxt[i];
        cz_r[i+1]    <= cz_nxt[i];
        czero_r[i+1] <= czero_r[i];
      end
    end
  end

  assign out_valid = cv_r[N];
  assign out_angle = czero_r[N] ? '0 : cz_r[N];

endmodule

`default_nettype wire

// ----- rtl/quaternion_to_euler_degrees.sv -----
// Top level of the quaternion to Euler angle (x-y-z) converter.
// Depends on qte_pkg, qte_yaw_ratio and qte_atan2.
`default_nettype none

// One quaternion transaction (x, y, z, w as signed Q1.15) enters and one
// result transaction leaves with pitch, yaw and roll in degrees, wrapped to
// [0,360) as unsigned fixed point with ANGLE_FRAC_BITS fraction bits, plus a
// degenerate flag for the all-zero quaternion (whose angles read zero). The
// block is fully pipelined and accepts one transaction every clock cycle
// while in_stall is low. Each transaction passes three register stages of
// capture, products and sums, 65 in the yaw ratio path (an operand register,
// a 31-stage bit-per-stage divider, a squaring stage, a radicand stage and a
// 31-stage digit-per-stage square root), 5 + CORDIC_STEPS in the atan2 units,
// and one in the output register. Pitch and roll operands ride along the yaw
// path so all three angles leave together. A two-entry output buffer
// decouples the sides: in_stall rises only when both entries hold results
// that the receiver has not yet taken, and then the whole pipeline holds
// without losing or repeating anything.

module quaternion_to_euler_degrees #(
  parameter int ANGLE_FRAC_BITS = 7,
  parameter int CORDIC_STEPS    = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  qte_pkg::quat_in_t   in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output qte_pkg::euler_out_t out_data
);
  import qte_pkg::*;

  localparam int ATAN_LAT = ATAN_PRE_STAGES + CORDIC_STEPS;
  localparam int SHIFT    = ACC_FRAC - ANGLE_FRAC_BITS;
  localparam logic signed [ANG_W-1:0] HALF = ANG_W'(2 ** (SHIFT - 1));
  localparam logic signed [ANG_W-1:0] FULL = ANG_W'(360 * (2 ** ANGLE_FRAC_BITS));

  // Round half up to the output format, then wrap a negative angle once.
  function automatic logic [OUT_W-1:0] to_deg(input logic signed [ANG_W-1:0] ang);
    logic signed [ANG_W-1:0] v;
    v = (ang + HALF) >>> SHIFT;
    if (v < 0) begin
      v = v + FULL;
    end
    return v[OUT_W-1:0];
  endfunction

  logic en;

  // Stage 1: captured quaternion.
  logic     s1_v_r;
  quat_in_t s1_q_r;

  // Stage 2: the ten component products.
  logic                     s2_v_r;
  logic signed [PROD_W-1:0] xx_r, yy_r, zz_r, ww_r, wx_r, yz_r, wy_r, zx_r, wz_r, xy_r;

  // Stage 3: norm, atan2 operands and the yaw numerator.
  logic                   s3_v_r;
  logic [NORM_W-1:0]      s3_n_r, s3_sm_r;
  side_t                  s3_side_r;
  logic signed [OP_W-1:0] n_sum, s_sum, s_mag;
  side_t                  side_nxt;

  // Yaw ratio path outputs.
  logic                   yr_valid;
  logic [QUO_W-1:0]       yr_ratio, yr_root;
  side_t                  yr_side;
  logic signed [OP_W-1:0] t_mag, t_val;

  // atan2 outputs and the flags that travel beside them.
  logic                    p_valid, y_valid, r_valid;
  logic signed [ANG_W-1:0] p_ang, y_ang, r_ang, yaw_sel;
  flag_t                   flg_r [0:ATAN_LAT-1];
  flag_t                   flg_nxt, flg_out;
  logic                    pipe_valid;
  euler_out_t              res;

  // Two-entry output buffer.
  logic [1:0] cnt_r, cnt_nxt;
  euler_out_t head_r, head_nxt, skid_r, skid_nxt;
  logic       push, pop;

  assign en       = cnt_r != 2'd2;
  assign in_stall = ~en;

  // Product and sum stages.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
    end else if (en) begin
      s1_v_r <= in_valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
    end
  end

  always_comb begin
    n_sum = OP_W'(xx_r) + OP_W'(yy_r) + OP_W'(zz_r) + OP_W'(ww_r);
    s_sum = (OP_W'(wy_r) - OP_W'(zx_r)) <<< 1;
    s_mag = s_sum[OP_W-1] ? -s_sum : s_sum;
    side_nxt.degenerate = n_sum == '0;
    side_nxt.s_neg      = s_sum[OP_W-1];
    side_nxt.pitch_y    = (OP_W'(wx_r) + OP_W'(yz_r)) <<< 1;
    side_nxt.pitch_x    = n_sum - ((OP_W'(xx_r) + OP_W'(yy_r)) <<< 1);
    side_nxt.roll_y     = (OP_W'(wz_r) + OP_W'(xy_r)) <<< 1;
    side_nxt.roll_x     = n_sum - ((OP_W'(yy_r) + OP_W'(zz_r)) <<< 1);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s1_q_r <= in_data;
      xx_r <= PROD_W'(s1_q_r.quat_x) * PROD_W'(s1_q_r.quat_x);
      yy_r <= PROD_W'(s1_q_r.quat_y) * PROD_W'(s1_q_r.quat_y);
      zz_r <= PROD_W'(s1_q_r.quat_z) * PROD_W'(s1_q_r.quat_z);
      ww_r <= PROD_W'(s1_q_r.quat_w) * PROD_W'(s1_q_r.quat_w);
      wx_r <= PROD_W'(s1_q_r.quat_w) * PROD_W'(s1_q_r.quat_x);
      yz_r <= PROD_W'(s1_q_r.quat_y) * PROD_W'(s1_q_r.quat_z);
      wy_r <= PROD_W'(s1_q_r.quat_w) * PROD_W'(s1_q_r.quat_y);
      zx_r <= PROD_W'(s1_q_r.quat_z) * PROD_W'(s1_q_r.quat_x);
      wz_r <= PROD_W'(s1_q_r.quat_w) * PROD_W'(s1_q_r.quat_z);
      xy_r <= PROD_W'(s1_q_r.quat_x) * PROD_W'(s1_q_r.quat_y);
      s3_n_r    <= n_sum[NORM_W-1:0];
      s3_sm_r   <= s_mag[NORM_W-1:0];
      s3_side_r <= side_nxt;
    end
  end

  // The yaw ratio |s| / n never exceeds one, since |s| <= n always holds.
  qte_yaw_ratio u_yaw_ratio (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (s3_v_r),
    .in_mag    (s3_sm_r),
    .in_norm   (s3_n_r),
    .in_side   (s3_side_r),
    .out_valid (yr_valid),
    .out_ratio (yr_ratio),
    .out_root  (yr_root),
    .out_side  (yr_side)
  );

  assign t_mag = OP_W'(yr_ratio);
  assign t_val = yr_side.s_neg ? -t_mag : t_mag;

  qte_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan_pitch (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (yr_valid),
    .in_y      (yr_side.pitch_y),
    .in_x      (yr_side.pitch_x),
    .out_valid (p_valid),
    .out_angle (p_ang)
  );

  qte_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan_yaw (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (yr_valid),
    .in_y      (t_val),
    .in_x      (OP_W'(yr_root)),
    .out_valid (y_valid),
    .out_angle (y_ang)
  );

  qte_atan2 #(.CORDIC_STEPS(CORDIC_STEPS)) u_atan_roll (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (yr_valid),
    .in_y      (yr_side.roll_y),
    .in_x      (yr_side.roll_x),
    .out_valid (r_valid),
    .out_angle (r_ang)
  );

  // A ratio that reaches one saturates yaw to plus or minus 90 degrees.
  assign flg_nxt.degenerate = yr_side.degenerate;
  assign flg_nxt.s_neg      = yr_side.s_neg;
  assign flg_nxt.sat        = yr_ratio[QUO_W-1];

  always_ff @(posedge clk) begin
    if (en) begin
      flg_r[0] <= flg_nxt;
      for (int k = 1; k < ATAN_LAT; k++) flg_r[k] <= flg_r[k-1];
    end
  end

  assign flg_out    = flg_r[ATAN_LAT-1];
  assign pipe_valid = p_valid & y_valid & r_valid;

  always_comb begin
    if (flg_out.sat) begin
      yaw_sel = flg_out.s_neg ? -DEG90 : DEG90;
    end else begin
      yaw_sel = y_ang;
    end
    if (flg_out.degenerate) begin
      res.pitch_deg  = '0;
      res.yaw_deg    = '0;
      res.roll_deg   = '0;
      res.degenerate = 1'b1;
    end else begin
      res.pitch_deg  = to_deg(p_ang);
      res.yaw_deg    = to_deg(yaw_sel);
      res.roll_deg   = to_deg(r_ang);
      res.degenerate = 1'b0;
    end
  end

  // Output buffer: head register drives the port, the skid entry catches
  // one more result while the head waits.
  assign push = en && pipe_valid;
  assign pop  = out_valid && !out_stall;

  always_comb begin
    cnt_nxt  = cnt_r;
    head_nxt = head_r;
    skid_nxt = skid_r;
    priority if (cnt_r == 2'd2) begin
      if (pop) begin
        head_nxt = skid_r;
        cnt_nxt  = 2'd1;
      end
    end else if (cnt_r == 2'd1) begin
      if (push && pop) begin
        head_nxt = res;
      end else if (push) begin
        skid_nxt = res;
        cnt_nxt  = 2'd2;
      end else if (pop) begin
        cnt_nxt = 2'd0;
      end
    end else begin
      if (push) begin
        head_nxt = res;
        cnt_nxt  = 2'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= 2'd0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    head_r <= head_nxt;
    skid_r <= skid_nxt;
  end

  assign out_valid = cnt_r != 2'd0;
  assign out_data  = head_r;

endmodule

`default_nettype wire

// ----- rtl/qte_checker.sv -----
// Port-level checks of the quaternion to Euler angle converter, bound to the
// top level. Depends on qte_pkg and quaternion_to_euler_degrees.
`default_nettype none

module qte_checker #(
  parameter int ANGLE_FRAC_BITS = 7
) (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input qte_pkg::quat_in_t   in_data,
  input logic                out_valid,
  input logic                out_stall,
  input qte_pkg::euler_out_t out_data
);
  import qte_pkg::*;

  localparam int FULL_CODE = 360 * (2 ** ANGLE_FRAC_BITS);

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_data))
    else $error("stalled quaternion transaction changed or was withdrawn");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result transaction dropped or changed");

  a_degenerate_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.degenerate |->
      out_data.pitch_deg == '0 && out_data.yaw_deg == '0 && out_data.roll_deg == '0)
    else $error("degenerate result carries nonzero angles");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (ANGLE_FRAC_BITS > 7) ||
      (out_data.pitch_deg < FULL_CODE && out_data.yaw_deg < FULL_CODE &&
       out_data.roll_deg < FULL_CODE))
    else $error("angle outside [0,360)");

  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall)
    else $error("input stalled with an empty output buffer");

endmodule

bind quaternion_to_euler_degrees qte_checker #(
  .ANGLE_FRAC_BITS(ANGLE_FRAC_BITS)
) u_qte_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .in_data   (in_data),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

`default_nettype wire
